[rtl/abtt_pkg.sv]
// Shared types and constants for the array binary tree traversal block.
`timescale 1ns / 1ps

package abtt_pkg;

  localparam int IDX_W = 6;
  localparam int KEY_W = 8;
  localparam int CNT_W = 7;

  localparam logic [KEY_W-1:0] EMPTY_MARK = 8'h2D;

  localparam logic [1:0] ACT_ROOT  = 2'd0;
  localparam logic [1:0] ACT_CHILD = 2'd1;
  localparam logic [1:0] ACT_WALK  = 2'd2;

  localparam logic [1:0] ORD_PRE   = 2'd0;
  localparam logic [1:0] ORD_IN    = 2'd1;
  localparam logic [1:0] ORD_POST  = 2'd2;
  localparam logic [1:0] ORD_LEVEL = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_PEMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE  = 2'd2;

  localparam int QDEPTH = 2;

  typedef enum logic [1:0] {
    CMD_ROOT,
    CMD_CHILD,
    CMD_RANGE_ERR,
    CMD_WALK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] parent;
    logic [IDX_W-1:0] child;
    logic [1:0]       order;
  } cmd_t;

endpackage

[rtl/abtt_queue.sv]
// Two-entry command queue between the front and back parts.
`timescale 1ns / 1ps

module abtt_queue
  import abtt_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic cmd_vld,
  output cmd_t cmd
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  cmd_t          ent_r [QDEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(QDEPTH));
  assign cmd_vld = (cnt_r != '0);
  assign cmd     = ent_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    if (push) begin
      wptr_nxt = (wptr_r == PW'(QDEPTH - 1)) ? '0 : wptr_r + PW'(1);
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PW'(QDEPTH - 1)) ? '0 : rptr_r + PW'(1);
    end
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/abtt_front.sv]
// Front part: node count register, input acceptance and command classification.
`timescale 1ns / 1ps

module abtt_front
  import abtt_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_action,
  input  logic [KEY_W-1:0] in_key,
  input  logic [IDX_W-1:0] in_parent_index,
  input  logic             in_child_side,
  input  logic [1:0]       in_walk_order,
  input  logic             q_full,
  output logic             q_push,
  output cmd_t             q_cmd,
  output logic [CNT_W-1:0] lim
);

  logic [CNT_W-1:0] node_count_r;
  logic [IDX_W+1:0] child_idx;
  logic             keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_W'(64);
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  assign lim = (node_count_r > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_r;

  assign child_idx = {1'b0, in_parent_index, 1'b1} + {{(IDX_W+1){1'b0}}, in_child_side};

  always_comb begin
    q_cmd.key    = in_key;
    q_cmd.parent = in_parent_index;
    q_cmd.child  = child_idx[IDX_W-1:0];
    q_cmd.order  = in_walk_order;
    q_cmd.kind   = CMD_ROOT;
    keep         = 1'b1;
    unique case (in_action)
      ACT_ROOT: begin
        q_cmd.kind = CMD_ROOT;
      end
      ACT_CHILD: begin
        // range check wins over the parent check
        q_cmd.kind = (child_idx >= {1'b0, lim}) ? CMD_RANGE_ERR : CMD_CHILD;
      end
      ACT_WALK: begin
        q_cmd.kind = CMD_WALK;
        keep       = (lim != '0);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

[rtl/abtt_back.sv]
// Back part: tree store, walk sequencer and result queue.
`timescale 1ns / 1ps

module abtt_back
  import abtt_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] lim,
  input  logic             cmd_vld,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [KEY_W-1:0] out_node_key,
  output logic [IDX_W-1:0] out_node_index,
  output logic             out_last
);

  localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PCHK,
    S_LEVEL,
    S_FIND,
    S_WALK
  } state_t;

  typedef enum logic [1:0] {
    DIR_DOWN,
    DIR_LEFT_DONE,
    DIR_RIGHT_DONE
  } dir_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    logic             last;
  } res_t;

  logic [KEY_W-1:0] mem [MAX_NODES];
  logic [KEY_W-1:0] rd_key_r;
  logic             rd_bit_r;

  state_t           state_r, state_nxt;
  dir_t             dir_r, dir_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [IDX_W-1:0] last_idx_r, last_idx_nxt;
  logic [1:0]       order_r, order_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [IDX_W-1:0] child_r, child_nxt;
  logic [MAX_NODES-1:0] valid_r, valid_nxt;

  logic             iss_vld_r, iss_vld_nxt;
  logic [1:0]       iss_status_r, iss_status_nxt;
  logic [IDX_W-1:0] iss_idx_r, iss_idx_nxt;
  logic             iss_last_r, iss_last_nxt;
  logic             iss_usekey_r, iss_usekey_nxt;

  res_t             ofifo_r [2];
  logic             owptr_r, owptr_nxt;
  logic             orptr_r, orptr_nxt;
  logic [1:0]       ocnt_r, ocnt_nxt;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [KEY_W-1:0] mem_wdata;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;

  logic             pop;
  logic             credit;
  logic [2:0]       occ;
  logic [IDX_W+1:0] left_idx, right_idx;
  logic             has_left, has_right;
  logic [IDX_W-1:0] cur_dec;
  logic [KEY_W-1:0] parent_key;
  logic             emit_here;
  res_t             land;

  assign pop       = (ocnt_r != 2'd0) && !out_stall;
  assign occ       = {1'b0, ocnt_r} - {2'b0, pop} + {2'b0, iss_vld_r};
  assign credit    = (occ < 3'd2);
  assign left_idx  = {1'b0, cur_r, 1'b1};
  assign right_idx = {1'b0, cur_r, 1'b0} + (IDX_W+2)'(2);
  assign has_left  = (left_idx < {1'b0, lim});
  assign has_right = (right_idx < {1'b0, lim});
  assign cur_dec   = cur_r - IDX_W'(1);
  assign parent_key = rd_bit_r ? rd_key_r : EMPTY_MARK;

  assign out_valid      = (ocnt_r != 2'd0);
  assign out_status     = ofifo_r[orptr_r].status;
  assign out_node_key   = ofifo_r[orptr_r].key;
  assign out_node_index = ofifo_r[orptr_r].idx;
  assign out_last       = ofifo_r[orptr_r].last;

  always_comb begin
    land.status = iss_status_r;
    land.key    = iss_usekey_r ? (rd_bit_r ? rd_key_r : EMPTY_MARK) : '0;
    land.idx    = iss_idx_r;
    land.last   = iss_last_r;
  end

  always_comb begin
    state_nxt      = state_r;
    dir_nxt        = dir_r;
    cur_nxt        = cur_r;
    last_idx_nxt   = last_idx_r;
    order_nxt      = order_r;
    key_nxt        = key_r;
    child_nxt      = child_r;
    valid_nxt      = valid_r;
    iss_vld_nxt    = 1'b0;
    iss_status_nxt = ST_OK;
    iss_idx_nxt    = cur_r;
    iss_last_nxt   = 1'b0;
    iss_usekey_nxt = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = child_r[AW-1:0];
    mem_wdata      = key_r;
    rd_en          = 1'b0;
    rd_addr        = cur_r[AW-1:0];
    cmd_pop        = 1'b0;
    emit_here      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_vld) begin
          unique case (cmd.kind)
            CMD_ROOT: begin
              if (credit) begin
                mem_we         = 1'b1;
                mem_waddr      = '0;
                mem_wdata      = cmd.key;
                valid_nxt[0]   = 1'b1;
                iss_vld_nxt    = 1'b1;
                iss_idx_nxt    = '0;
                iss_last_nxt   = 1'b1;
                cmd_pop        = 1'b1;
              end
            end
            CMD_RANGE_ERR: begin
              if (credit) begin
                iss_vld_nxt    = 1'b1;
                iss_status_nxt = ST_RANGE;
                iss_idx_nxt    = '0;
                iss_last_nxt   = 1'b1;
                cmd_pop        = 1'b1;
              end
            end
            CMD_CHILD: begin
              // fetch the parent key; S_PCHK decides once the result queue has room
              rd_en     = 1'b1;
              rd_addr   = cmd.parent[AW-1:0];
              key_nxt   = cmd.key;
              child_nxt = cmd.child;
              cmd_pop   = 1'b1;
              state_nxt = S_PCHK;
            end
            CMD_WALK: begin
              cmd_pop   = 1'b1;
              order_nxt = cmd.order;
              cur_nxt   = '0;
              dir_nxt   = DIR_DOWN;
              if (cmd.order == ORD_LEVEL) begin
                state_nxt = S_LEVEL;
              end else if (cmd.order == ORD_POST) begin
                last_idx_nxt = '0;
                state_nxt    = S_WALK;
              end else begin
                state_nxt = S_FIND;
              end
            end
            default: ;
          endcase
        end
      end

      S_PCHK: begin
        if (credit) begin
          iss_vld_nxt  = 1'b1;
          iss_idx_nxt  = child_r;
          iss_last_nxt = 1'b1;
          if (parent_key == EMPTY_MARK) begin
            iss_status_nxt = ST_PEMPTY;
          end else begin
            mem_we                       = 1'b1;
            valid_nxt[child_r[AW-1:0]]   = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end

      S_LEVEL: begin
        if (credit) begin
          iss_vld_nxt    = 1'b1;
          iss_usekey_nxt = 1'b1;
          iss_last_nxt   = ({1'b0, cur_r} + CNT_W'(1) == lim);
          rd_en          = 1'b1;
          if ({1'b0, cur_r} + CNT_W'(1) == lim) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt = cur_r + IDX_W'(1);
          end
        end
      end

      S_FIND: begin
        // locate the node that closes the walk: rightmost leaf for preorder,
        // end of the right spine for inorder
        if (has_right) begin
          cur_nxt = right_idx[IDX_W-1:0];
        end else if (has_left && order_r == ORD_PRE) begin
          cur_nxt = left_idx[IDX_W-1:0];
        end else begin
          last_idx_nxt = cur_r;
          cur_nxt      = '0;
          dir_nxt      = DIR_DOWN;
          state_nxt    = S_WALK;
        end
      end

      S_WALK: begin
        unique case (dir_r)
          DIR_DOWN:       emit_here = (order_r == ORD_PRE);
          DIR_LEFT_DONE:  emit_here = (order_r == ORD_IN);
          DIR_RIGHT_DONE: emit_here = (order_r == ORD_POST);
          default:        emit_here = 1'b0;
        endcase
        if (!emit_here || credit) begin
          if (emit_here) begin
            iss_vld_nxt    = 1'b1;
            iss_usekey_nxt = 1'b1;
            iss_last_nxt   = (cur_r == last_idx_r);
            rd_en          = 1'b1;
          end
          unique case (dir_r)
            DIR_DOWN: begin
              if (has_left) begin
                cur_nxt = left_idx[IDX_W-1:0];
              end else begin
                dir_nxt = DIR_LEFT_DONE;
              end
            end
            DIR_LEFT_DONE: begin
              if (has_right) begin
                cur_nxt = right_idx[IDX_W-1:0];
                dir_nxt = DIR_DOWN;
              end else begin
                dir_nxt = DIR_RIGHT_DONE;
              end
            end
            DIR_RIGHT_DONE: begin
              if (cur_r == '0) begin
                state_nxt = S_IDLE;
              end else begin
                // climb: an odd slot is a left child
                cur_nxt = {1'b0, cur_dec[IDX_W-1:1]};
                dir_nxt = cur_r[0] ? DIR_LEFT_DONE : DIR_RIGHT_DONE;
              end
            end
            default: ;
          endcase
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    owptr_nxt = owptr_r ^ iss_vld_r;
    orptr_nxt = orptr_r ^ pop;
    ocnt_nxt  = ocnt_r + {1'b0, iss_vld_r} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      iss_vld_r <= 1'b0;
      owptr_r   <= 1'b0;
      orptr_r   <= 1'b0;
      ocnt_r    <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      iss_vld_r <= iss_vld_nxt;
      owptr_r   <= owptr_nxt;
      orptr_r   <= orptr_nxt;
      ocnt_r    <= ocnt_nxt;
    end
    dir_r        <= dir_nxt;
    cur_r        <= cur_nxt;
    last_idx_r   <= last_idx_nxt;
    order_r      <= order_nxt;
    key_r        <= key_nxt;
    child_r      <= child_nxt;
    iss_status_r <= iss_status_nxt;
    iss_idx_r    <= iss_idx_nxt;
    iss_last_r   <= iss_last_nxt;
    iss_usekey_r <= iss_usekey_nxt;
    if (iss_vld_r) begin
      ofifo_r[owptr_r] <= land;
    end
  end

  // tree store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_key_r <= mem[rd_addr];
      rd_bit_r <= valid_r[rd_addr];
    end
  end

endmodule

[rtl/array_binary_tree_traversal.sv]
// Top level of the array binary tree traversal block.
// Keeps a heap-ordered tree of 8-bit keys (children of slot i at 2i+1, 2i+2).
// Input channel in_*: set root, set child or walk, accepted when in_valid is
// high and in_stall low. Result channel out_*: status, key, slot, last flag;
// the receiver holds it with out_stall, and the payload stays put meanwhile.
// cfg_we/cfg_wdata write the node count; write it only while the block idles.
// A root or child write gives one result, which passes through the command
// queue, the sequencer issue register and the result queue; a child write
// also passes the parent lookup. A level-order walk gives one result per
// cycle while out_stall is low. Depth-first walks take one sequencer step per
// visit of a node and visit each node three times, after a search for the
// node that closes the walk (none for postorder); the single read port of the
// store and this step sequencer set that pace, and a step that emits waits for
// room in the result queue. Two commands queue between front and back, so
// input is still accepted while a walk drains into a stalled
// receiver, until the queue holds two commands.
// Reset marks every slot empty at once (per-slot valid bits), restores the
// node count to 64 and drops all queued commands and pending results.
`timescale 1ns / 1ps

module array_binary_tree_traversal
  import abtt_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_action,
  input  logic [KEY_W-1:0] in_key,
  input  logic [IDX_W-1:0] in_parent_index,
  input  logic             in_child_side,
  input  logic [1:0]       in_walk_order,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [KEY_W-1:0] out_node_key,
  output logic [IDX_W-1:0] out_node_index,
  output logic             out_last
);

  logic             q_full;
  logic             q_push;
  cmd_t             q_in;
  logic             q_pop;
  logic             q_vld;
  cmd_t             q_out;
  logic [CNT_W-1:0] lim;

  abtt_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_key          (in_key),
    .in_parent_index (in_parent_index),
    .in_child_side   (in_child_side),
    .in_walk_order   (in_walk_order),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (q_in),
    .lim             (lim)
  );

  abtt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .cmd_vld  (q_vld),
    .cmd      (q_out)
  );

  abtt_back #(
    .MAX_NODES(MAX_NODES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .lim            (lim),
    .cmd_vld        (q_vld),
    .cmd            (q_out),
    .cmd_pop        (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_node_key   (out_node_key),
    .out_node_index (out_node_index),
    .out_last       (out_last)
  );

endmodule
